// File: rtl/assert_macros.svh
// assertion macros used by the msb-first bit reader unit
// each macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/msbbr_pkg.sv
// package for the msb-first bit reader: function codes, microcode word and program rom
// no dependencies
package msbbr_pkg;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_SEEK   = 2'd2;
    localparam logic [1:0] FUNC_REWIND = 2'd3;

    localparam logic [2:0] BIT_IN_BYTE_MASK = 3'h7;
    localparam logic [7:0] BYTE_MASK        = 8'hff;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_LOAD,
        OP_RDSETUP,
        OP_COLLECT,
        OP_SEEK,
        OP_REWIND,
        OP_FINISH,
        OP_NONE
    } uop_t;

    typedef enum logic [1:0] {
        JMP_ALWAYS,
        JMP_DISPATCH,
        JMP_ZERO,
        JMP_MORE
    } jmp_t;

    typedef logic [2:0] step_t;

    typedef struct packed {
        uop_t  op;
        jmp_t  jmp;
        step_t target;
    } ucode_t;

    localparam step_t STEP_IDLE    = 3'd0;
    localparam step_t STEP_RDSETUP = 3'd1;
    localparam step_t STEP_COLLECT = 3'd2;
    localparam step_t STEP_FINISH  = 3'd3;
    localparam step_t STEP_LOAD    = 3'd4;
    localparam step_t STEP_SEEK    = 3'd5;
    localparam step_t STEP_REWIND  = 3'd6;

    // conditional jumps fall through to step + 1 when the condition is false
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_IDLE:    w = '{OP_ACCEPT,  JMP_DISPATCH, STEP_IDLE};
            STEP_RDSETUP: w = '{OP_RDSETUP, JMP_ZERO,     STEP_FINISH};
            STEP_COLLECT: w = '{OP_COLLECT, JMP_MORE,     STEP_COLLECT};
            STEP_FINISH:  w = '{OP_FINISH,  JMP_ALWAYS,   STEP_IDLE};
            STEP_LOAD:    w = '{OP_LOAD,    JMP_ALWAYS,   STEP_FINISH};
            STEP_SEEK:    w = '{OP_SEEK,    JMP_ALWAYS,   STEP_FINISH};
            STEP_REWIND:  w = '{OP_REWIND,  JMP_ALWAYS,   STEP_FINISH};
            default:      w = '{OP_NONE,    JMP_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic step_t dispatch(input logic [1:0] func);
        step_t s;
        unique case (func)
            FUNC_LOAD:   s = STEP_LOAD;
            FUNC_READ:   s = STEP_RDSETUP;
            FUNC_SEEK:   s = STEP_SEEK;
            FUNC_REWIND: s = STEP_REWIND;
            default:     s = STEP_IDLE;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/msb_first_bit_reader_unit.sv
// msb-first bitstream reader: byte store, bit position, microcoded load/read/seek/rewind sequencer
// depends on msbbr_pkg and assert_macros.svh
//
// channel  | direction | handshake         | fields
// ---------+-----------+-------------------+----------------------------------------------
// command  | in        | start, busy       | func, byte_in, restart, bit_count, seek_offset
// result   | out       | done (one cycle)  | value, bits_read, position, end_of_data
//
// load, seek and rewind pass through accept, their own step and finish; a read passes through accept,
// setup, a collect step for each stored byte the bits span (at most 9 for 64 bits) and finish
// the read loop fetches one byte per cycle over the single read port of the byte store
// done rises in the cycle busy drops, so the next command can be taken with the result
// rst_n clears position and length; the byte store needs no clearing, nothing unwritten is read
`include "assert_macros.svh"

module msb_first_bit_reader_unit
    import msbbr_pkg::*;
#(
    parameter int BUFFER_BYTES  = 4096,
    parameter int MAX_READ_BITS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [7:0]         byte_in,
    input  logic               restart,
    input  logic [6:0]         bit_count,
    input  logic signed [16:0] seek_offset,
    output logic               done,
    output logic [63:0]        value,
    output logic [6:0]         bits_read,
    output logic [15:0]        position,
    output logic               end_of_data
);

    localparam int LEN_W  = $clog2(BUFFER_BYTES * 8 + 1);
    localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CNT_W  = $clog2(MAX_READ_BITS + 1);
    localparam int CMP_W  = (LEN_W > 7) ? LEN_W : 7;
    localparam int SEEK_W = ((LEN_W > 17) ? LEN_W : 17) + 2;

    // control state
    step_t              step_reg, step_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               done_reg, done_next;

    // captured command word and read datapath
    logic [7:0]         byte_reg, byte_next;
    logic               restart_reg, restart_next;
    logic [6:0]         count_reg, count_next;
    logic signed [16:0] offset_reg, offset_next;
    logic [63:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]   taken_reg, taken_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [2:0]         bitoff_reg, bitoff_next;
    logic [ADDR_W-1:0]  raddr_reg, raddr_next;

    // result word
    logic [63:0]        value_reg, value_next;
    logic [6:0]         bits_read_reg, bits_read_next;
    logic [15:0]        position_reg, position_next;
    logic               eod_reg, eod_next;

    // byte store
    logic [7:0]         byte_mem [0:BUFFER_BYTES-1];
    logic [7:0]         rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  waddr;

    ucode_t             uc;
    logic               cond;

    logic [6:0]         cnt_cap;
    logic [LEN_W-1:0]   left;
    logic [3:0]         avail;
    logic [3:0]         take_k;
    logic [7:0]         chunk;
    logic signed [SEEK_W-1:0] seek_sum;

    function automatic logic bit_count_cap_needed(input logic [6:0] c);
        return (c > 7'(MAX_READ_BITS));
    endfunction

    assign uc = ucode_rom(step_reg);

    always_comb
    begin
        step_next      = step_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        done_next      = 1'b0;
        byte_next      = byte_reg;
        restart_next   = restart_reg;
        count_next     = count_reg;
        offset_next    = offset_reg;
        acc_next       = acc_reg;
        taken_next     = taken_reg;
        rem_next       = rem_reg;
        bitoff_next    = bitoff_reg;
        raddr_next     = raddr_reg;
        value_next     = value_reg;
        bits_read_next = bits_read_reg;
        position_next  = position_reg;
        eod_next       = eod_reg;
        mem_we         = 1'b0;
        waddr          = len_reg[3 +: ADDR_W];
        cond           = 1'b0;

        cnt_cap  = (bit_count_cap_needed(count_reg)) ? 7'(MAX_READ_BITS) : count_reg;
        left     = len_reg - pos_reg;
        avail    = 4'd8 - {1'b0, bitoff_reg};
        take_k   = (CNT_W'(avail) < rem_reg) ? avail : rem_reg[3:0];
        chunk    = (rdata_reg & (BYTE_MASK >> bitoff_reg)) >> (avail - take_k);
        seek_sum = SEEK_W'(signed'({1'b0, pos_reg})) + SEEK_W'(offset_reg);

        case (uc.op)
            OP_ACCEPT:
            begin
                byte_next    = byte_in;
                restart_next = restart;
                count_next   = bit_count;
                offset_next  = seek_offset;
                acc_next     = '0;
                taken_next   = '0;
            end
            OP_LOAD:
            begin
                if (restart_reg)
                begin
                    pos_next = '0;
                    waddr    = '0;
                    mem_we   = 1'b1;
                    len_next = LEN_W'(8);
                end
                else if ((len_reg >> 3) < LEN_W'(BUFFER_BYTES))
                begin
                    mem_we   = 1'b1;
                    len_next = len_reg + LEN_W'(8);
                end
            end
            OP_RDSETUP:
            begin
                if (CMP_W'(left) < CMP_W'(cnt_cap))
                    taken_next = CNT_W'(left);
                else
                    taken_next = CNT_W'(cnt_cap);
                rem_next    = taken_next;
                pos_next    = pos_reg + LEN_W'(taken_next);
                raddr_next  = pos_reg[3 +: ADDR_W];
                bitoff_next = pos_reg[2:0] & BIT_IN_BYTE_MASK;
                cond        = (taken_next == '0);
            end
            OP_COLLECT:
            begin
                // take the rest of this byte or what is still wanted, then fetch the next
                acc_next    = (acc_reg << take_k) | {56'd0, chunk};
                rem_next    = rem_reg - CNT_W'(take_k);
                bitoff_next = '0;
                raddr_next  = raddr_reg + ADDR_W'(1);
                cond        = (rem_next != '0);
            end
            OP_SEEK:
            begin
                if (seek_sum < 0)
                    pos_next = '0;
                else if (seek_sum > SEEK_W'(signed'({1'b0, len_reg})))
                    pos_next = len_reg;
                else
                    pos_next = seek_sum[LEN_W-1:0];
            end
            OP_REWIND:
            begin
                pos_next = '0;
            end
            OP_FINISH:
            begin
                value_next     = acc_reg;
                bits_read_next = 7'(taken_reg);
                position_next  = 16'(pos_reg);
                eod_next       = (pos_reg >= len_reg);
                done_next      = 1'b1;
            end
            default:
            begin
            end
        endcase

        case (uc.jmp)
            JMP_DISPATCH: step_next = start ? dispatch(func) : STEP_IDLE;
            JMP_ZERO,
            JMP_MORE:     step_next = cond ? uc.target : step_reg + step_t'(1);
            default:      step_next = uc.target;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            len_reg  <= '0;
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        restart_reg   <= restart_next;
        count_reg     <= count_next;
        offset_reg    <= offset_next;
        acc_reg       <= acc_next;
        taken_reg     <= taken_next;
        rem_reg       <= rem_next;
        bitoff_reg    <= bitoff_next;
        raddr_reg     <= raddr_next;
        value_reg     <= value_next;
        bits_read_reg <= bits_read_next;
        position_reg  <= position_next;
        eod_reg       <= eod_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            byte_mem[waddr] <= byte_reg;
        rdata_reg <= byte_mem[raddr_next];
    end

    assign busy        = (step_reg != STEP_IDLE);
    assign done        = done_reg;
    assign value       = value_reg;
    assign bits_read   = bits_read_reg;
    assign position    = position_reg;
    assign end_of_data = eod_reg;

    `ASSERT_ALWAYS(a_pos_in_range, pos_reg <= len_reg, "position beyond data length")
    `ASSERT_ALWAYS(a_rem_bounded, (step_reg != STEP_COLLECT) || (rem_reg != '0 &&
        rem_reg <= CNT_W'(MAX_READ_BITS)), "read loop entered with bad remaining count")
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule
